>>> src/pit_pkg.sv
// Shared constants and types of the point-in-tetrahedron test.
// Used by pit_mac and point_in_tetrahedron_test; depends on nothing.
package pit_pkg;

  // Default coordinate width (signed Q4.12 at 16 bits)
  localparam int COORD_WIDTH_DEF = 16;

  // Threshold register
  localparam int              THRESH_WIDTH = 40;
  localparam logic [39:0]     THRESH_RESET = 40'd6872;

  // Input opcodes
  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_TEST = 1'b1;

  // What the accumulate stage does with the registered product
  typedef enum logic [2:0] {
    ACC_NONE,
    ACC_TRI_FIRST,
    ACC_TRI_ADD,
    ACC_DET_LO,
    ACC_DET_HI
  } acc_op_e;

  typedef struct packed {
    acc_op_e op;
    logic    first;  // start a new determinant sum
    logic    neg;    // subtract this term
  } acc_ctl_t;

endpackage

>>> src/pit_mac.sv
// Shared multiplier with its two accumulators (3x3 minor and 4x4 determinant).
// Depends on pit_pkg for the accumulate control struct.
module pit_mac import pit_pkg::*; #(
  parameter int COORD_WIDTH = COORD_WIDTH_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  acc_ctl_t                          ctl_i,
  input  logic signed [COORD_WIDTH-1:0]     mul_a_i,
  input  logic signed [COORD_WIDTH+2:0]     mul_b_i,
  output logic signed [2*COORD_WIDTH+2:0]   tri_o,
  output logic signed [3*COORD_WIDTH+5:0]   det_o
);

  localparam int ProdW   = 2 * COORD_WIDTH + 3;
  localparam int DetW    = 3 * COORD_WIDTH + 6;
  localparam int HiShift = COORD_WIDTH + 2;

  acc_ctl_t                ctl_q;
  logic signed [ProdW-1:0] prod_d, prod_q;
  logic signed [ProdW-1:0] tri_d, tri_q;
  logic signed [DetW-1:0]  det_d, det_q;
  logic signed [DetW-1:0]  term, base, sum, dif;

  // Multiply stage
  assign prod_d = mul_a_i * mul_b_i;

  // Accumulate stage: minor sum and determinant sum
  always_comb begin
    term = DetW'(prod_q);
    if (ctl_q.op == ACC_DET_HI) begin
      term = term <<< HiShift;
    end
    base  = ctl_q.first ? '0 : det_q;
    sum   = base + term;
    dif   = base - term;
    tri_d = tri_q;
    det_d = det_q;
    case (ctl_q.op)
      ACC_TRI_FIRST: tri_d = prod_q;
      ACC_TRI_ADD:   tri_d = tri_q + prod_q;
      ACC_DET_LO,
      ACC_DET_HI:    det_d = ctl_q.neg ? dif : sum;
      default:       ;
    endcase
  end

  // Hold the operation tag alongside its product
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl_q <= '{op: ACC_NONE, first: 1'b0, neg: 1'b0};
    end else begin
      ctl_q <= ctl_i;
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q <= prod_d;
    tri_q  <= tri_d;
    det_q  <= det_d;
  end

  assign tri_o = tri_q;
  assign det_o = det_q;

endmodule

>>> src/point_in_tetrahedron_test.sv
// Point-in-tetrahedron test: vertex store, sequencer and result register.
// Load beats leave the block idle, ready for the next beat; a test beat stalls the input until
// its result goes to the output register, and ends early when the tetrahedron is degenerate,
// D0 is zero or a sign mismatches. Each determinant uses the one shared multiplier for 4 minors
// x 3 products, a gap, and two partial products per column term.
// Reset clears vertices to zero and loads the threshold default. Depends on pit_pkg, pit_mac.
module point_in_tetrahedron_test import pit_pkg::*; #(
  parameter int COORD_WIDTH = COORD_WIDTH_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [THRESH_WIDTH-1:0]       cfg_wdata_i,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic                          opcode_i,
  input  logic [1:0]                    vertex_index_i,
  input  logic signed [COORD_WIDTH-1:0] x_coord_i,
  input  logic signed [COORD_WIDTH-1:0] y_coord_i,
  input  logic signed [COORD_WIDTH-1:0] z_coord_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic                          inside_res_o,
  output logic                          degenerate_o
);

  localparam int OpbW    = COORD_WIDTH + 3;
  localparam int ProdW   = 2 * COORD_WIDTH + 3;
  localparam int DetW    = 3 * COORD_WIDTH + 6;
  localparam int HiShift = COORD_WIDTH + 2;
  localparam int CmpW    = (DetW > THRESH_WIDTH) ? DetW : THRESH_WIDTH;
  localparam logic [2:0] KLast = 3'd4;

  typedef enum logic [2:0] {
    ST_IDLE, ST_RUN, ST_DRAIN, ST_MAG, ST_CMP, ST_SIGN, ST_DONE
  } state_e;

  typedef enum logic [2:0] {
    SL_TRI0, SL_TRI1, SL_TRI2, SL_GAP, SL_DET_LO, SL_DET_HI
  } slot_e;

  state_e state_d, state_q;
  slot_e  slot_d, slot_q;
  logic [1:0] t_d, t_q;
  logic [2:0] k_d, k_q;
  logic res_inside_d, res_inside_q, res_degen_d, res_degen_q;
  logic out_valid_d, out_valid_q, inside_d, inside_q, degen_d, degen_q;

  logic signed [COORD_WIDTH-1:0] vx_q [4];
  logic signed [COORD_WIDTH-1:0] vy_q [4];
  logic signed [COORD_WIDTH-1:0] vz_q [4];
  logic signed [COORD_WIDTH-1:0] px_q, py_q, pz_q;
  logic [THRESH_WIDTH-1:0]       thr_q;

  logic signed [COORD_WIDTH-1:0] row_x [4];
  logic signed [COORD_WIDTH-1:0] row_y [4];
  logic signed [COORD_WIDTH-1:0] row_z [4];

  logic [1:0] p_idx, q_idx, r_idx, ya, za, zb;
  acc_ctl_t   ctl;
  logic signed [COORD_WIDTH-1:0] mul_a;
  logic signed [OpbW-1:0]        mul_b;
  logic signed [ProdW-1:0]       tri_val;
  logic signed [DetW-1:0]        det_val, det_abs;
  logic [CmpW-1:0]               mag_d, mag_q;
  logic d0_neg_q, d0_zero_q;
  logic in_acc, degen_hit, sign_ok;

  assign in_acc = in_valid_i && !in_stall_o;

  // Store vertices and the threshold register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 4; i++) begin
        vx_q[i] <= '0;
        vy_q[i] <= '0;
        vz_q[i] <= '0;
      end
      thr_q <= THRESH_RESET;
    end else begin
      if (in_acc && opcode_i == OP_LOAD) begin
        vx_q[vertex_index_i] <= x_coord_i;
        vy_q[vertex_index_i] <= y_coord_i;
        vz_q[vertex_index_i] <= z_coord_i;
      end
      if (cfg_we_i) begin
        thr_q <= cfg_wdata_i;
      end
    end
  end

  // Capture the test point
  always_ff @(posedge clk_i) begin
    if (in_acc && opcode_i == OP_TEST) begin
      px_q <= x_coord_i;
      py_q <= y_coord_i;
      pz_q <= z_coord_i;
    end
  end

  // Rows of the current matrix: determinant k swaps row k-1 for the point
  always_comb begin
    for (int i = 0; i < 4; i++) begin
      if (k_q != 3'd0 && 3'(i) == k_q - 3'd1) begin
        row_x[i] = px_q;
        row_y[i] = py_q;
        row_z[i] = pz_q;
      end else begin
        row_x[i] = vx_q[i];
        row_y[i] = vy_q[i];
        row_z[i] = vz_q[i];
      end
    end
  end

  // Pick operands for the current slot: minor of the rows other than t
  always_comb begin
    p_idx = (t_q == 2'd0) ? 2'd1 : 2'd0;
    q_idx = (t_q <= 2'd1) ? 2'd2 : 2'd1;
    r_idx = (t_q == 2'd3) ? 2'd2 : 2'd3;
    ya = r_idx;
    za = p_idx;
    zb = q_idx;
    case (slot_q)
      SL_TRI0: begin
        ya = p_idx;
        za = q_idx;
        zb = r_idx;
      end
      SL_TRI1: begin
        ya = q_idx;
        za = r_idx;
        zb = p_idx;
      end
      default: ;
    endcase

    ctl   = '{op: ACC_NONE, first: 1'b0, neg: 1'b0};
    mul_a = row_y[ya];
    mul_b = OpbW'(row_z[za]) - OpbW'(row_z[zb]);
    if (state_q == ST_RUN) begin
      unique case (slot_q)
        SL_TRI0:   ctl.op = ACC_TRI_FIRST;
        SL_TRI1,
        SL_TRI2:   ctl.op = ACC_TRI_ADD;
        SL_GAP:    ctl.op = ACC_NONE;
        SL_DET_LO: begin
          ctl   = '{op: ACC_DET_LO, first: (t_q == 2'd0), neg: t_q[0]};
          mul_a = row_x[t_q];
          mul_b = $signed({1'b0, tri_val[HiShift-1:0]});
        end
        SL_DET_HI: begin
          ctl   = '{op: ACC_DET_HI, first: 1'b0, neg: t_q[0]};
          mul_a = row_x[t_q];
          mul_b = OpbW'($signed(tri_val[ProdW-1:HiShift]));
        end
        default:   ctl.op = ACC_NONE;
      endcase
    end
  end

  pit_mac #(
    .COORD_WIDTH(COORD_WIDTH)
  ) u_mac (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctl_i  (ctl),
    .mul_a_i(mul_a),
    .mul_b_i(mul_b),
    .tri_o  (tri_val),
    .det_o  (det_val)
  );

  // Magnitude of D0 and the sign checks
  assign det_abs   = det_val[DetW-1] ? -det_val : det_val;
  assign mag_d     = CmpW'($unsigned(det_abs));
  assign degen_hit = mag_q < CmpW'(thr_q);
  assign sign_ok   = (det_val != '0) && (det_val[DetW-1] == d0_neg_q);

  always_ff @(posedge clk_i) begin
    if (state_q == ST_MAG) begin
      mag_q     <= mag_d;
      d0_neg_q  <= det_val[DetW-1];
      d0_zero_q <= (det_val == '0);
    end
  end

  // Sequencer next state
  always_comb begin
    state_d      = state_q;
    slot_d       = slot_q;
    t_d          = t_q;
    k_d          = k_q;
    res_inside_d = res_inside_q;
    res_degen_d  = res_degen_q;
    out_valid_d  = out_valid_q && out_stall_i;
    inside_d     = inside_q;
    degen_d      = degen_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_acc && opcode_i == OP_TEST) begin
          state_d = ST_RUN;
          slot_d  = SL_TRI0;
          t_d     = 2'd0;
          k_d     = 3'd0;
        end
      end
      ST_RUN: begin
        unique case (slot_q)
          SL_TRI0:   slot_d = SL_TRI1;
          SL_TRI1:   slot_d = SL_TRI2;
          SL_TRI2:   slot_d = SL_GAP;
          SL_GAP:    slot_d = SL_DET_LO;
          SL_DET_LO: slot_d = SL_DET_HI;
          SL_DET_HI: begin
            slot_d = SL_TRI0;
            t_d    = t_q + 2'd1;
            if (t_q == 2'd3) begin
              state_d = ST_DRAIN;
            end
          end
          default:   slot_d = SL_TRI0;
        endcase
      end
      ST_DRAIN: begin
        state_d = (k_q == 3'd0) ? ST_MAG : ST_SIGN;
      end
      ST_MAG: begin
        state_d = ST_CMP;
      end
      ST_CMP: begin
        if (degen_hit || d0_zero_q) begin
          res_inside_d = 1'b0;
          res_degen_d  = degen_hit;
          state_d      = ST_DONE;
        end else begin
          k_d     = 3'd1;
          slot_d  = SL_TRI0;
          t_d     = 2'd0;
          state_d = ST_RUN;
        end
      end
      ST_SIGN: begin
        res_degen_d = 1'b0;
        if (!sign_ok) begin
          res_inside_d = 1'b0;
          state_d      = ST_DONE;
        end else if (k_q == KLast) begin
          res_inside_d = 1'b1;
          state_d      = ST_DONE;
        end else begin
          k_d     = k_q + 3'd1;
          slot_d  = SL_TRI0;
          t_d     = 2'd0;
          state_d = ST_RUN;
        end
      end
      ST_DONE: begin
        // Hand the result to the output register once it is free
        if (!out_valid_q || !out_stall_i) begin
          out_valid_d = 1'b1;
          inside_d    = res_inside_q;
          degen_d     = res_degen_q;
          state_d     = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      slot_q       <= SL_TRI0;
      t_q          <= 2'd0;
      k_q          <= 3'd0;
      res_inside_q <= 1'b0;
      res_degen_q  <= 1'b0;
      out_valid_q  <= 1'b0;
      inside_q     <= 1'b0;
      degen_q      <= 1'b0;
    end else begin
      state_q      <= state_d;
      slot_q       <= slot_d;
      t_q          <= t_d;
      k_q          <= k_d;
      res_inside_q <= res_inside_d;
      res_degen_q  <= res_degen_d;
      out_valid_q  <= out_valid_d;
      inside_q     <= inside_d;
      degen_q      <= degen_d;
    end
  end

  assign in_stall_o   = (state_q != ST_IDLE);
  assign out_valid_o  = out_valid_q;
  assign inside_res_o = inside_q;
  assign degenerate_o = degen_q;

  // A new result only ever comes from the finishing state
  a_result_from_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(state_q == ST_DONE))
    else $error("result beat appeared outside the finishing state");

  // A degenerate tetrahedron never reports an inside point
  a_degen_not_inside: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(inside_res_o && degenerate_o))
    else $error("degenerate result flagged as inside");

  // An accepted test beat makes the block busy
  a_test_goes_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o && opcode_i == OP_TEST) |=> in_stall_o)
    else $error("test beat accepted without starting the sequencer");

  // A load beat produces no result
  a_load_no_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o && opcode_i == OP_LOAD) |=> !$rose(out_valid_o))
    else $error("load beat produced a result");

endmodule
